### sv/kne_pkg.sv
// Shared types, character codes and limits for the keyword number extractor.
package kne_pkg;

  localparam int unsigned KEY_MAX_DEF     = 8;
  localparam int unsigned MANT_DIGITS_DEF = 18;

  localparam int unsigned MATCH_W    = 4;
  localparam int unsigned DIGITS_W   = 5;
  localparam int unsigned EXPACC_W   = 7;
  localparam int unsigned PARSED_W   = 17;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned MANT_W     = 60;
  localparam int unsigned EXP_W      = 8;
  localparam int unsigned KEYWORD_W  = 64;
  localparam int unsigned KEYLEN_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [DIGITS_W-1:0] DIGITS_SAT = 5'd31;
  localparam logic [EXPACC_W-1:0] EXP_SAT    = 7'd99;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PART_INT  = 3'b001,
    PART_FRAC = 3'b010,
    PART_EXP  = 3'b100
  } part_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEYWORD = 2'd0,
    CFG_KEYLEN  = 2'd1,
    CFG_SKIP    = 2'd2,
    CFG_MAX     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [KEYWORD_W-1:0] keyword_bytes;
    logic [KEYLEN_W-1:0]  keyword_length;
    logic [COUNT_W-1:0]   skip_count;
    logic [COUNT_W-1:0]   max_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic                    kind;
    logic                    negative;
    logic [MANT_W-1:0]       mantissa;
    logic signed [EXP_W-1:0] exponent_ten;
    logic                    digits_overflow;
    logic                    short_count;
    logic [COUNT_W-1:0]      value_count;
  } result_t;

endpackage

### sv/kne_cfg.sv
// Configuration register file of the keyword number extractor.
module kne_cfg import kne_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEYWORD_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEYWORD: cfg_d.keyword_bytes  = cfg_data_i;
        CFG_KEYLEN:  cfg_d.keyword_length = cfg_data_i[KEYLEN_W-1:0];
        CFG_SKIP:    cfg_d.skip_count     = cfg_data_i[COUNT_W-1:0];
        CFG_MAX:     cfg_d.max_count      = cfg_data_i[COUNT_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keyword_bytes  <= '0;
      cfg_q.keyword_length <= KEYLEN_W'(1);
      cfg_q.skip_count     <= '0;
      cfg_q.max_count      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/kne_core.sv
// Keyword matcher and number parser state with its combinational next-state logic.
module kne_core import kne_pkg::*; #(
  parameter int unsigned KEY_MAX     = KEY_MAX_DEF,
  parameter int unsigned MANT_DIGITS = MANT_DIGITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    step_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam logic [MATCH_W-1:0]  KeyMax = MATCH_W'(KEY_MAX);
  localparam logic [DIGITS_W-1:0] MantDigits = DIGITS_W'(MANT_DIGITS);

  logic [MATCH_W-1:0]  match_q, match_d;
  logic                in_number_q, in_number_d;
  part_e               part_q, part_d;
  logic                neg_q, neg_d;
  logic [MANT_W-1:0]   mant_q, mant_d;
  logic [DIGITS_W-1:0] mdig_q, mdig_d;
  logic [DIGITS_W-1:0] fdig_q, fdig_d;
  logic [EXPACC_W-1:0] expacc_q, expacc_d;
  logic                skip_q, skip_d;
  logic                ovf_q, ovf_d;
  logic [PARSED_W-1:0] parsed_q, parsed_d;
  logic [COUNT_W-1:0]  emitted_q, emitted_d;
  logic                halted_q, halted_d;

  logic [7:0]          ch;
  logic [3:0]          digit;
  logic                is_digit;
  logic                is_blank;
  logic [MATCH_W-1:0]  key_len;
  logic [MATCH_W-1:0]  pos;
  logic [MATCH_W-1:0]  pos_next;
  logic [7:0]          key_byte;
  logic [63:0]         mant_x10;
  logic [9:0]          exp_x10;
  logic [DIGITS_W-1:0] dropped;
  logic signed [8:0]   exp_sum;
  logic [COUNT_W-1:0]  emitted_inc;

  assign ch       = item_i.text_byte;
  assign digit    = 4'(ch - CH_ZERO);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_blank = (ch == CH_BS) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_SPACE);

  always_comb begin
    if (cfg_i.keyword_length == '0) begin
      key_len = MATCH_W'(1);
    end else if (cfg_i.keyword_length > KeyMax) begin
      key_len = KeyMax;
    end else begin
      key_len = cfg_i.keyword_length;
    end
  end

  assign pos      = (match_q >= key_len) ? '0 : match_q;
  assign key_byte = cfg_i.keyword_bytes[pos[2:0]*8 +: 8];
  assign pos_next = (ch == key_byte) ? pos + MATCH_W'(1) : '0;

  assign mant_x10 = {1'b0, mant_q, 3'b000} + {3'b000, mant_q, 1'b0} + 64'(digit);
  assign exp_x10  = {expacc_q, 3'b000} + {2'b00, expacc_q, 1'b0} + 10'(digit);
  assign dropped  = (mdig_q > MantDigits) ? mdig_q - MantDigits : '0;
  assign exp_sum  = 9'(expacc_q) + 9'(dropped) - 9'(fdig_q);
  assign emitted_inc = (emitted_q == '1) ? emitted_q : emitted_q + COUNT_W'(1);

  always_comb begin
    match_d     = match_q;
    in_number_d = in_number_q;
    part_d      = part_q;
    neg_d       = neg_q;
    mant_d      = mant_q;
    mdig_d      = mdig_q;
    fdig_d      = fdig_q;
    expacc_d    = expacc_q;
    skip_d      = skip_q;
    ovf_d       = ovf_q;
    parsed_d    = parsed_q;
    emitted_d   = emitted_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (item_i.end_of_stream) begin
      res_valid_o       = 1'b1;
      res_o.kind        = 1'b1;
      res_o.short_count = (cfg_i.max_count != '0) && (emitted_q < cfg_i.max_count);
      res_o.value_count = emitted_q;
      match_d     = '0;
      in_number_d = 1'b0;
      part_d      = PART_INT;
      neg_d       = 1'b0;
      mant_d      = '0;
      mdig_d      = '0;
      fdig_d      = '0;
      expacc_d    = '0;
      skip_d      = 1'b0;
      ovf_d       = 1'b0;
      parsed_d    = '0;
      emitted_d   = '0;
      halted_d    = 1'b0;
    end else if (!halted_q) begin
      if (!in_number_q) begin
        match_d = pos_next;
        if (pos_next >= key_len) begin
          match_d     = '0;
          in_number_d = 1'b1;
          part_d      = PART_INT;
          neg_d       = 1'b0;
          mant_d      = '0;
          mdig_d      = '0;
          fdig_d      = '0;
          expacc_d    = '0;
          skip_d      = 1'b0;
          ovf_d       = 1'b0;
        end
      end else if (skip_q) begin
        skip_d = 1'b0;
      end else if (is_digit) begin
        unique case (part_q)
          PART_EXP: begin
            expacc_d = (exp_x10 > 10'(EXP_SAT)) ? EXP_SAT : exp_x10[EXPACC_W-1:0];
          end
          PART_FRAC: begin
            if (mdig_q < MantDigits) begin
              mant_d = mant_x10[MANT_W-1:0];
              mdig_d = mdig_q + DIGITS_W'(1);
              fdig_d = fdig_q + DIGITS_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          PART_INT: begin
            if (mdig_q < MantDigits) begin
              mant_d = mant_x10[MANT_W-1:0];
            end else begin
              ovf_d = 1'b1;
            end
            if (mdig_q < DIGITS_SAT) begin
              mdig_d = mdig_q + DIGITS_W'(1);
            end
          end
          default: part_d = part_q;
        endcase
      end else if (ch == CH_DOT) begin
        part_d = PART_FRAC;
      end else if (ch == CH_MINUS) begin
        neg_d = 1'b1;
      end else if ((ch == CH_LOW_E) || (ch == CH_UP_E)) begin
        part_d = PART_EXP;
        skip_d = 1'b1;
      end else if (!is_blank) begin
        in_number_d = 1'b0;
        if (parsed_q != '1) begin
          parsed_d = parsed_q + PARSED_W'(1);
        end
        if (parsed_q >= PARSED_W'(cfg_i.skip_count)) begin
          res_valid_o           = 1'b1;
          res_o.negative        = neg_q;
          res_o.mantissa        = mant_q;
          res_o.exponent_ten    = (exp_sum > $signed(9'd99)) ? 8'sd99 : exp_sum[EXP_W-1:0];
          res_o.digits_overflow = ovf_q;
          emitted_d = emitted_inc;
          halted_d  = (cfg_i.max_count != '0) && (emitted_inc >= cfg_i.max_count);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= '0;
      in_number_q <= 1'b0;
      part_q      <= PART_INT;
      neg_q       <= 1'b0;
      mant_q      <= '0;
      mdig_q      <= '0;
      fdig_q      <= '0;
      expacc_q    <= '0;
      skip_q      <= 1'b0;
      ovf_q       <= 1'b0;
      parsed_q    <= '0;
      emitted_q   <= '0;
      halted_q    <= 1'b0;
    end else if (step_i) begin
      match_q     <= match_d;
      in_number_q <= in_number_d;
      part_q      <= part_d;
      neg_q       <= neg_d;
      mant_q      <= mant_d;
      mdig_q      <= mdig_d;
      fdig_q      <= fdig_d;
      expacc_q    <= expacc_d;
      skip_q      <= skip_d;
      ovf_q       <= ovf_d;
      parsed_q    <= parsed_d;
      emitted_q   <= emitted_d;
      halted_q    <= halted_d;
    end
  end

endmodule

### sv/kne_out_stage.sv
// Result register that drives the master-side stream and packs its payload.
module kne_out_stage import kne_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  result_t               res_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {1'b0, res_q.value_count, res_q.short_count, res_q.digits_overflow,
                          res_q.exponent_ten, res_q.mantissa, res_q.negative};

endmodule

### sv/keyword_number_extractor_top.sv
// Top level of the keyword number extractor: input register, parser core and result register.
//
// The block scans a byte stream on the slave channel for a configured keyword and then
// parses the decimal number that follows it. Each kept number leaves on the master
// channel as one transaction with tuser low; an input transaction with tlast high ends
// the stream and returns a status transaction with tuser high, then the parse state
// clears so that a new stream can begin. Configuration is written through the cfg
// channel, which is always ready; the user must write it only while no transaction is
// in flight, which the block does not enforce. Each input transaction is captured in
// an input register and handled by the parser core; a result, if any, is registered in
// the result register, which drives the master port. One byte is taken per cycle while
// no byte is held back. When the receiver stalls, the result register holds its data;
// bytes that produce no result keep flowing, and a byte that produces a result waits in
// the input register, with s_axis_tready low, until the result register is free. Reset clears
// the control and parse state and loads the register reset values (keyword length one).
module keyword_number_extractor_top import kne_pkg::*; #(
  parameter int unsigned KEY_MAX     = KEY_MAX_DEF,
  parameter int unsigned MANT_DIGITS = MANT_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // text_byte
  input  logic                  s_axis_tlast,   // end_of_stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // negative, mantissa[59:0], exponent_ten[7:0], digits_overflow, short_count,
  // value_count[15:0], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,   // kind
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [KEYWORD_W-1:0]  cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q, item_valid_d;
  logic    res_valid;
  result_t res;
  logic    out_free;
  logic    step;
  logic    in_accept;

  assign step          = item_valid_q && (!res_valid || out_free);
  assign s_axis_tready = !item_valid_q || step;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (step) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.text_byte     <= s_axis_tdata;
      item_q.end_of_stream <= s_axis_tlast;
    end
  end

  kne_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kne_core #(
    .KEY_MAX     (KEY_MAX),
    .MANT_DIGITS (MANT_DIGITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item_q),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  kne_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step && res_valid),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### test/tb_top.sv
// Self-checking testbench for the keyword number extractor top level.
`timescale 1ns / 100ps

module tb_top;
  import kne_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [7:0]            s_data = '0;
  logic                  s_last = 1'b0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  m_user;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_e              cfg_index = CFG_KEYWORD;
  logic [KEYWORD_W-1:0]  cfg_data = '0;

  always #5 clk = ~clk;

  keyword_number_extractor_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  item_t   text_q[$];
  result_t extracted_q[$];
  int      n_bytes_queued = 0;
  int      n_bytes_taken = 0;
  int      n_reports_predicted = 0;
  int      n_reports_seen = 0;
  int      n_errors = 0;
  int      quiet_cycles = 0;
  bit      idle_en = 1'b1;
  int      src_gap = 0;
  int      snk_gap = 0;

  logic [63:0] kw_text = '0;
  int          kw_len_text = 1;

  logic [63:0] kw_reg = '0;
  logic [3:0]  kw_len_reg = 4'd1;
  logic [15:0] skip_reg = '0;
  logic [15:0] max_reg = '0;

  int          match_pos = 0;
  bit          in_num = 1'b0;
  part_e       num_part = PART_INT;
  bit          neg_seen = 1'b0;
  logic [63:0] mant_acc = '0;
  int          mant_digs = 0;
  int          frac_digs = 0;
  int          exp_acc = 0;
  bit          skip_next = 1'b0;
  bit          ovf_seen = 1'b0;
  int          n_parsed = 0;
  int          n_emitted = 0;
  bit          halted = 1'b0;

  task automatic clear_stream();
    match_pos = 0;
    in_num    = 1'b0;
    num_part  = PART_INT;
    neg_seen  = 1'b0;
    mant_acc  = '0;
    mant_digs = 0;
    frac_digs = 0;
    exp_acc   = 0;
    skip_next = 1'b0;
    ovf_seen  = 1'b0;
    n_parsed  = 0;
    n_emitted = 0;
    halted    = 1'b0;
  endtask

  task automatic extract_step(input item_t it, output bit hit, output result_t r);
    int len;
    int d;
    int held;
    int dropped;
    int e;
    bit keep;
    logic [7:0] ch;
    ch  = it.text_byte;
    hit = 1'b0;
    r   = '0;
    if (it.end_of_stream) begin
      hit           = 1'b1;
      r.kind        = 1'b1;
      r.short_count = (max_reg != 0) && (n_emitted < max_reg);
      r.value_count = n_emitted[15:0];
      clear_stream();
    end else if (halted) begin
      hit = 1'b0;
    end else if (!in_num) begin
      len = (kw_len_reg == 0) ? 1 : kw_len_reg;
      if (len > KEY_MAX_DEF) len = KEY_MAX_DEF;
      if (match_pos >= len) match_pos = 0;
      if (ch == kw_reg[8*match_pos +: 8]) match_pos++;
      else match_pos = 0;
      if (match_pos >= len) begin
        match_pos = 0;
        in_num    = 1'b1;
        num_part  = PART_INT;
        neg_seen  = 1'b0;
        mant_acc  = '0;
        mant_digs = 0;
        frac_digs = 0;
        exp_acc   = 0;
        skip_next = 1'b0;
        ovf_seen  = 1'b0;
      end
    end else if (skip_next) begin
      skip_next = 1'b0;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d    = ch - CH_ZERO;
      held = (mant_digs < MANT_DIGITS_DEF) ? mant_digs : MANT_DIGITS_DEF;
      case (num_part)
        PART_EXP: begin
          exp_acc = exp_acc * 10 + d;
          if (exp_acc > int'(EXP_SAT)) exp_acc = EXP_SAT;
        end
        PART_FRAC: begin
          if (held < MANT_DIGITS_DEF) begin
            mant_acc = mant_acc * 10 + d;
            mant_digs++;
            frac_digs++;
          end else begin
            ovf_seen = 1'b1;
          end
        end
        default: begin
          if (held < MANT_DIGITS_DEF) mant_acc = mant_acc * 10 + d;
          else ovf_seen = 1'b1;
          if (mant_digs < DIGITS_SAT) mant_digs++;
        end
      endcase
    end else if (ch == CH_DOT) begin
      num_part = PART_FRAC;
    end else if (ch == CH_MINUS) begin
      neg_seen = 1'b1;
    end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
      num_part  = PART_EXP;
      skip_next = 1'b1;
    end else if (ch == CH_BS || ch == CH_TAB || ch == CH_SPACE || ch == CH_LF) begin
      hit = 1'b0;
    end else begin
      keep   = n_parsed >= skip_reg;
      in_num = 1'b0;
      if (n_parsed < 131071) n_parsed++;
      if (keep) begin
        dropped           = (mant_digs > MANT_DIGITS_DEF) ? mant_digs - MANT_DIGITS_DEF : 0;
        e                 = exp_acc + dropped - frac_digs;
        if (e > int'(EXP_SAT)) e = EXP_SAT;
        hit               = 1'b1;
        r.negative        = neg_seen;
        r.mantissa        = mant_acc[MANT_W-1:0];
        r.exponent_ten    = e[7:0];
        r.digits_overflow = ovf_seen;
        if (n_emitted < 65535) n_emitted++;
        if (max_reg != 0 && n_emitted >= max_reg) halted = 1'b1;
      end
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t r;
    bit      hit;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        n_reports_seen <= n_reports_seen + 1;
        if (extracted_q.size() == 0) begin
          $error("unexpected result transaction: tuser %0b tdata %h", m_user, m_data);
          n_errors++;
        end else begin
          want = extracted_q.pop_front();
          check_field("kind", want.kind, m_user);
          check_field("negative", want.negative, m_data[0]);
          check_field("mantissa", want.mantissa, m_data[60:1]);
          check_field("exponent_ten", $signed(want.exponent_ten), $signed(m_data[68:61]));
          check_field("digits_overflow", want.digits_overflow, m_data[69]);
          check_field("short_count", want.short_count, m_data[70]);
          check_field("value_count", want.value_count, m_data[86:71]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEYWORD: kw_reg     = cfg_data;
          CFG_KEYLEN:  kw_len_reg = cfg_data[3:0];
          CFG_SKIP:    skip_reg   = cfg_data[15:0];
          CFG_MAX:     max_reg    = cfg_data[15:0];
          default:     kw_reg     = kw_reg;
        endcase
      end
      if (s_valid && s_ready) begin
        extract_step('{text_byte: s_data, end_of_stream: s_last}, hit, r);
        if (hit) begin
          extracted_q.push_back(r);
          n_reports_predicted <= n_reports_predicted + 1;
        end
        n_bytes_taken <= n_bytes_taken + 1;
      end
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (src_gap > 0) begin
        s_valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (text_q.size() > 0) begin
        nxt     = text_q.pop_front();
        s_valid <= 1'b1;
        s_data  <= nxt.text_byte;
        s_last  <= nxt.end_of_stream;
        if (idle_en && $urandom_range(0, 4) == 0) src_gap <= $urandom_range(1, 4);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (snk_gap > 0) begin
      m_ready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      m_ready <= 1'b0;
      snk_gap <= $urandom_range(0, 3);
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic push_byte(logic [7:0] b);
    text_q.push_back('{text_byte: b, end_of_stream: 1'b0});
    n_bytes_queued++;
  endtask

  task automatic push_eos();
    text_q.push_back('{text_byte: 8'($urandom_range(0, 255)), end_of_stream: 1'b1});
    n_bytes_queued++;
  endtask

  function automatic bit is_number_char(logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_MINUS ||
           b == CH_LOW_E || b == CH_UP_E || b == CH_BS || b == CH_TAB ||
           b == CH_SPACE || b == CH_LF;
  endfunction

  task automatic push_digits(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 29);
      case (sel)
        0:       push_byte(CH_BS);
        1:       push_byte(CH_TAB);
        2:       push_byte(CH_SPACE);
        3:       push_byte(CH_LF);
        4:       push_byte(CH_MINUS);
        default: push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      endcase
    end
  endtask

  task automatic push_number();
    if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS);
    push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(17, 35) : $urandom_range(0, 6));
    if ($urandom_range(0, 1) == 1) begin
      push_byte(CH_DOT);
      push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(0, 6));
    end
    if ($urandom_range(0, 2) == 0) begin
      push_byte($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
      push_byte(($urandom_range(0, 2) == 0) ? 8'h2b : 8'($urandom_range(0, 255)));
      push_digits($urandom_range(0, 4));
    end
  endtask

  task automatic push_segment();
    int sel;
    int n;
    int i;
    logic [7:0] term;
    sel = $urandom_range(0, 15);
    if (sel < 2) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
    end else if (sel < 4) begin
      n = $urandom_range(0, kw_len_text - 1);
      for (i = 0; i < n; i++) push_byte(kw_text[8*i +: 8]);
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      for (i = 0; i < kw_len_text; i++) push_byte(kw_text[8*i +: 8]);
      push_number();
      if (sel == 4) begin
        push_eos();
      end else begin
        do term = 8'($urandom_range(0, 255)); while (is_number_char(term));
        push_byte(term);
      end
    end
    if ($urandom_range(0, 11) == 0) push_eos();
  endtask

  task automatic fill_text(int n);
    int start;
    start = n_bytes_queued;
    while (n_bytes_queued - start < n) push_segment();
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (n_bytes_taken != n_bytes_queued || n_reports_seen != n_reports_predicted);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_send(cfg_idx_e idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(logic [63:0] kw, logic [3:0] len, logic [15:0] skip,
                              logic [15:0] lim);
    cfg_valid <= 1'b1;
    cfg_send(CFG_KEYWORD, kw);
    cfg_send(CFG_KEYLEN, 64'(len));
    cfg_send(CFG_SKIP, 64'(skip));
    cfg_send(CFG_MAX, 64'(lim));
    cfg_valid   <= 1'b0;
    kw_text     = kw;
    kw_len_text = (len == 0) ? 1 : (len > KEY_MAX_DEF) ? KEY_MAX_DEF : len;
  endtask

  task automatic run_phase(logic [63:0] kw, logic [3:0] len, logic [15:0] skip,
                           logic [15:0] lim, int n);
    write_config(kw, len, skip, lim);
    fill_text(n);
    push_eos();
    wait_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_byte(8'h00);
    push_byte(CH_MINUS);
    push_byte("1");
    push_byte(CH_DOT);
    push_byte("5");
    push_byte(CH_LOW_E);
    push_byte("+");
    push_byte("2");
    push_byte(";");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte("9");
    push_byte(CH_TAB);
    push_byte(CH_SPACE);
    push_byte(CH_BS);
    push_byte(CH_LF);
    push_byte(CH_ZERO);
    push_byte(CH_UP_E);
    push_byte("x");
    push_byte("9");
    push_byte("9");
    push_byte("9");
    push_byte(8'hFF);
    push_eos();
    wait_drain();

    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'd0, 16'd0, 100);

    write_config({$urandom, $urandom}, 4'($urandom_range(1, 8)), 16'd2, 16'd5);
    fill_text(50);
    wait_drain();
    fill_text(50);
    push_eos();
    wait_drain();

    run_phase({$urandom, $urandom}, 4'd0, 16'd0, 16'd1, 80);
    run_phase({$urandom, $urandom}, 4'd15, 16'hFFFF, 16'hFFFF, 50);

    idle_en = 1'b0;
    run_phase({$urandom, $urandom}, 4'd3, 16'd0, 16'd0, 150);

    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### keyword_number_extractor_top.f
sv/kne_pkg.sv
sv/kne_cfg.sv
sv/kne_core.sv
sv/kne_out_stage.sv
sv/keyword_number_extractor_top.sv
test/tb_top.sv
